// ===== sv/kmeans_histogram_keyframe_select_defines.svh =====
// ----------------------------------------------------------------------------
// Key-frame selector: assertion macros
// Concurrent check helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KMEANS_HISTOGRAM_KEYFRAME_SELECT_DEFINES_SVH
`define KMEANS_HISTOGRAM_KEYFRAME_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
`define KMHKS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("kmhks: check failed");
`define KMHKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmhks: check failed");
`else
`define KMHKS_ASSERT(lbl, expr)
`define KMHKS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/kmhks_pkg.sv =====
// ----------------------------------------------------------------------------
// Key-frame selector package
// Shared widths, defaults, controller states, datapath operations and status.
// ----------------------------------------------------------------------------
`default_nettype none
package kmhks_pkg;

  localparam int BIN_COUNT_DEF    = 16;
  localparam int MAX_FRAMES_DEF   = 1024;
  localparam int MAX_CLUSTERS_DEF = 16;

  localparam int BIN_VALUE_W   = 16;
  localparam int CFG_W         = 5;
  localparam int CLUSTER_IDX_W = 4;
  localparam int FRAME_IDX_W   = 10;
  localparam int CENT_W        = 24;
  localparam int FRAC_W        = 8;
  localparam int PASS_W        = 9;
  localparam logic [PASS_W-1:0] PASS_LIMIT = 9'd500;

  typedef enum logic [4:0] {
    S_IDLE, S_PAD, S_SEED_RD, S_SEED_WR, S_CLR, S_ARD, S_DRD, S_DACC, S_DCMP,
    S_AWR, S_SRD, S_SWR, S_UCHK, S_URD, S_UGO, S_UDIV, S_PEND, S_SCHK, S_SARD,
    S_SMAT, S_SDRD, S_SDACC, S_SCMP, S_SLD, S_SOUT, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PAD, OP_START, OP_SEED_RD, OP_SEED_WR, OP_CLR,
    OP_FRAME, OP_DRD, OP_DACC, OP_DCMP, OP_AWR, OP_SRD, OP_SWR, OP_UCHK,
    OP_URD, OP_DIVGO, OP_UWR, OP_PEND, OP_SCHK, OP_SARD, OP_SMAT, OP_SCMP,
    OP_SLD, OP_NEXTC, OP_CLEAR
  } op_t;

  typedef struct packed {
    logic b_last;
    logic c_last;
    logic i_last;
    logic pad_busy;
    logic n_zero;
    logic cnt_zero;
    logic stop;
    logic div_done;
    logic asg_hit;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/kmhks_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module kmhks_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== sv/kmhks_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient, one bit per cycle, done pulses when it is ready.
// ----------------------------------------------------------------------------
`default_nettype none
module kmhks_div #(
  parameter int DV_W = 34,
  parameter int DS_W = 11
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [DV_W-1:0] dividend,
  input  wire logic [DS_W-1:0] divisor,
  output logic                 done,
  output logic      [DV_W-1:0] quot
);
  localparam int CW = $clog2(DV_W + 1);

  logic [DS_W-1:0] rem_r;
  logic [DS_W-1:0] dsr_r;
  logic [DV_W-1:0] quo_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DS_W:0]   trial;
  logic            fits;

  assign trial = {rem_r, quo_r[DV_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dsr_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= fits ? DS_W'(trial - {1'b0, dsr_r}) : DS_W'(trial);
        quo_r <= {quo_r[DV_W-2:0], fits};
        cnt_r <= CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(DV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule
`default_nettype wire

// ===== sv/kmhks_ctrl.sv =====
// ----------------------------------------------------------------------------
// Key-frame selector controller
// Sequences loading, seeding, k-means passes and key-frame selection.
// ----------------------------------------------------------------------------
`default_nettype none
module kmhks_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_end_of_set,
  input  wire logic             out_ready,
  input  wire kmhks_pkg::stat_t st,
  output logic                  in_ready,
  output logic                  out_valid,
  output kmhks_pkg::op_t        op
);
  import kmhks_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (in_end_of_set) state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        if (st.pad_busy) begin
          op = OP_PAD;
        end else if (st.n_zero) begin
          op        = OP_CLEAR;
          state_nxt = S_IDLE;
        end else begin
          op        = OP_START;
          state_nxt = S_SEED_RD;
        end
      end
      S_SEED_RD: begin
        op        = OP_SEED_RD;
        state_nxt = S_SEED_WR;
      end
      S_SEED_WR: begin
        op        = OP_SEED_WR;
        state_nxt = (st.b_last && st.c_last) ? S_CLR : S_SEED_RD;
      end
      S_CLR: begin
        op = OP_CLR;
        if (st.b_last && st.c_last) state_nxt = S_ARD;
      end
      S_ARD: begin
        op        = OP_FRAME;
        state_nxt = S_DRD;
      end
      S_DRD: begin
        op        = OP_DRD;
        state_nxt = S_DACC;
      end
      S_DACC: begin
        op        = OP_DACC;
        state_nxt = st.b_last ? S_DCMP : S_DRD;
      end
      S_DCMP: begin
        op        = OP_DCMP;
        state_nxt = st.c_last ? S_AWR : S_DRD;
      end
      S_AWR: begin
        op        = OP_AWR;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        op        = OP_SRD;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        op = OP_SWR;
        if (st.b_last) state_nxt = st.i_last ? S_UCHK : S_ARD;
        else           state_nxt = S_SRD;
      end
      S_UCHK: begin
        op = OP_UCHK;
        if (st.cnt_zero) state_nxt = st.c_last ? S_PEND : S_UCHK;
        else             state_nxt = S_URD;
      end
      S_URD: begin
        op        = OP_URD;
        state_nxt = S_UGO;
      end
      S_UGO: begin
        op        = OP_DIVGO;
        state_nxt = S_UDIV;
      end
      S_UDIV: begin
        if (st.div_done) begin
          op = OP_UWR;
          if (st.b_last) state_nxt = st.c_last ? S_PEND : S_UCHK;
          else           state_nxt = S_URD;
        end
      end
      S_PEND: begin
        op        = OP_PEND;
        state_nxt = st.stop ? S_SCHK : S_CLR;
      end
      S_SCHK: begin
        op = OP_SCHK;
        if (st.cnt_zero) state_nxt = st.c_last ? S_FIN : S_SCHK;
        else             state_nxt = S_SARD;
      end
      S_SARD: begin
        op        = OP_SARD;
        state_nxt = S_SMAT;
      end
      S_SMAT: begin
        op = OP_SMAT;
        if (st.asg_hit) state_nxt = S_SDRD;
        else            state_nxt = st.i_last ? S_SLD : S_SARD;
      end
      S_SDRD: begin
        op        = OP_DRD;
        state_nxt = S_SDACC;
      end
      S_SDACC: begin
        op        = OP_DACC;
        state_nxt = st.b_last ? S_SCMP : S_SDRD;
      end
      S_SCMP: begin
        op        = OP_SCMP;
        state_nxt = st.i_last ? S_SLD : S_SARD;
      end
      S_SLD: begin
        op        = OP_SLD;
        state_nxt = S_SOUT;
      end
      S_SOUT: begin
        if (out_ready) begin
          op        = OP_NEXTC;
          state_nxt = st.c_last ? S_FIN : S_SCHK;
        end
      end
      S_FIN: begin
        op        = OP_CLEAR;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SOUT);
endmodule
`default_nettype wire

// ===== sv/kmhks_dp.sv =====
// ----------------------------------------------------------------------------
// Key-frame selector datapath
// Frame, centroid, sum and assignment stores, loop counters, L1 distance
// accumulator, mean divider and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module kmhks_dp #(
  parameter int BIN_COUNT    = kmhks_pkg::BIN_COUNT_DEF,
  parameter int MAX_FRAMES   = kmhks_pkg::MAX_FRAMES_DEF,
  parameter int MAX_CLUSTERS = kmhks_pkg::MAX_CLUSTERS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire kmhks_pkg::op_t                        op,
  output kmhks_pkg::stat_t                           st,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [kmhks_pkg::CFG_W-1:0]           cfg_wr_data,
  input  wire logic [kmhks_pkg::BIN_VALUE_W-1:0]     in_bin_value,
  output logic      [kmhks_pkg::CLUSTER_IDX_W-1:0]   out_cluster_index,
  output logic      [kmhks_pkg::FRAME_IDX_W-1:0]     out_frame_index,
  output logic                                       out_last_result
);
  import kmhks_pkg::*;

  localparam int BIN_W  = $clog2(BIN_COUNT);
  localparam int FI_W   = $clog2(MAX_FRAMES);
  localparam int FR_W   = $clog2(MAX_FRAMES + 1);
  localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int FA_W   = $clog2(MAX_FRAMES * BIN_COUNT);
  localparam int CA_W   = $clog2(MAX_CLUSTERS * BIN_COUNT);
  localparam int DIST_W = CENT_W + BIN_W;
  localparam int SUM_W  = BIN_VALUE_W + FI_W;
  localparam int DV_W   = SUM_W + FRAC_W;
  localparam int LIMIT  = (MAX_CLUSTERS < 16) ? MAX_CLUSTERS : 16;

  function automatic logic [FA_W-1:0] f_addr(input logic [FI_W-1:0] f,
                                             input logic [BIN_W-1:0] b);
    f_addr = FA_W'(FA_W'(f) * FA_W'(BIN_COUNT) + FA_W'(b));
  endfunction

  function automatic logic [CA_W-1:0] c_addr(input logic [CL_W-1:0] c,
                                             input logic [BIN_W-1:0] b);
    c_addr = CA_W'(CA_W'(c) * CA_W'(BIN_COUNT) + CA_W'(b));
  endfunction

  logic [CFG_W-1:0]  cc_r;
  logic [CFG_W-1:0]  k_r;
  logic [BIN_W-1:0]  bin_pos_r;
  logic [FR_W-1:0]   frames_r;
  logic [PASS_W-1:0] pass_r;
  logic [FI_W-1:0]   fi_r;
  logic [CL_W-1:0]   ci_r;
  logic [BIN_W-1:0]  bi_r;
  logic [CL_W-1:0]   best_r;
  logic [FI_W-1:0]   bestf_r;
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W-1:0] bd_r;
  logic              found_r;
  logic              changed_r;
  logic [FR_W-1:0]   cnt_r [MAX_CLUSTERS];
  logic [CLUSTER_IDX_W-1:0] out_cl_r;
  logic [FRAME_IDX_W-1:0]   out_fr_r;
  logic                     out_last_r;

  // Store ports.
  logic              f_we, f_re, c_we, c_re, s_we, s_re, a_we, a_re;
  logic [FA_W-1:0]   f_waddr, f_raddr;
  logic [CA_W-1:0]   c_waddr, c_raddr, s_waddr, s_raddr;
  logic [BIN_VALUE_W-1:0] f_wdata, f_q;
  logic [CENT_W-1:0] c_wdata, c_q;
  logic [SUM_W-1:0]  s_wdata, s_q;
  logic [CL_W-1:0]   a_q;

  logic              div_start, div_done;
  logic [DV_W-1:0]   quot;

  logic              b_last, c_last, i_last, better, last_c, frm_room;
  logic [CENT_W-1:0] x_val, adiff;
  logic [CFG_W-1:0]  k_clamp;

  assign b_last   = bi_r == BIN_W'(BIN_COUNT - 1);
  assign c_last   = CFG_W'(ci_r) == CFG_W'(k_r - 1'b1);
  assign i_last   = FR_W'(fi_r) == FR_W'(frames_r - 1'b1);
  assign better   = !found_r || (acc_r < bd_r);
  assign frm_room = frames_r < FR_W'(MAX_FRAMES);

  assign x_val = {f_q, {FRAC_W{1'b0}}};
  assign adiff = (x_val >= c_q) ? CENT_W'(x_val - c_q) : CENT_W'(c_q - x_val);

  always_comb begin
    k_clamp = (cc_r == '0) ? CFG_W'(1) : cc_r;
    if (32'(k_clamp) > 32'(LIMIT)) k_clamp = CFG_W'(LIMIT);
    if (32'(k_clamp) > 32'(frames_r)) k_clamp = CFG_W'(frames_r);
  end

  // The reported result is the last one unless a later cluster has members.
  always_comb begin
    last_c = 1'b1;
    for (int j = 0; j < MAX_CLUSTERS; j++) begin
      if (CL_W'(j) > ci_r && cnt_r[j] != '0) last_c = 1'b0;
    end
  end

  always_comb begin
    f_we    = (op == OP_LOAD && frm_room) || op == OP_PAD;
    f_waddr = f_addr(FI_W'(frames_r), bin_pos_r);
    f_wdata = (op == OP_LOAD) ? in_bin_value : '0;
    f_re    = op == OP_SEED_RD || op == OP_DRD || op == OP_SRD;
    f_raddr = (op == OP_SEED_RD) ? f_addr(FI_W'(ci_r), bi_r) : f_addr(fi_r, bi_r);

    c_we    = op == OP_SEED_WR || op == OP_UWR;
    c_waddr = c_addr(ci_r, bi_r);
    c_wdata = (op == OP_SEED_WR) ? x_val : quot[CENT_W-1:0];
    c_re    = op == OP_DRD;
    c_raddr = c_addr(ci_r, bi_r);

    s_we    = op == OP_CLR || op == OP_SWR;
    s_waddr = (op == OP_SWR) ? c_addr(best_r, bi_r) : c_addr(ci_r, bi_r);
    s_wdata = (op == OP_SWR) ? SUM_W'(s_q + SUM_W'(f_q)) : '0;
    s_re    = op == OP_SRD || op == OP_URD;
    s_raddr = (op == OP_SRD) ? c_addr(best_r, bi_r) : c_addr(ci_r, bi_r);

    a_we    = op == OP_AWR;
    a_re    = op == OP_FRAME || op == OP_SARD;

    div_start = op == OP_DIVGO;
  end

  kmhks_ram #(.WIDTH(BIN_VALUE_W), .DEPTH(MAX_FRAMES * BIN_COUNT)) u_feat (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_q)
  );

  kmhks_ram #(.WIDTH(CENT_W), .DEPTH(MAX_CLUSTERS * BIN_COUNT)) u_cent (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_q)
  );

  kmhks_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CLUSTERS * BIN_COUNT)) u_sum (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_q)
  );

  kmhks_ram #(.WIDTH(CL_W), .DEPTH(MAX_FRAMES)) u_asg (
    .clk, .we(a_we), .waddr(fi_r), .wdata(best_r),
    .re(a_re), .raddr(fi_r), .rdata(a_q)
  );

  kmhks_div #(.DV_W(DV_W), .DS_W(FR_W)) u_div (
    .clk, .rst_n, .start(div_start),
    .dividend({s_q, {FRAC_W{1'b0}}}), .divisor(cnt_r[ci_r]),
    .done(div_done), .quot
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r      <= CFG_W'(1);
      k_r       <= CFG_W'(1);
      bin_pos_r <= '0;
      frames_r  <= '0;
      pass_r    <= '0;
      fi_r      <= '0;
      ci_r      <= '0;
      bi_r      <= '0;
      found_r   <= 1'b0;
      changed_r <= 1'b0;
      for (int j = 0; j < MAX_CLUSTERS; j++) cnt_r[j] <= '0;
    end else begin
      if (cfg_wr_en) cc_r <= cfg_wr_data;
      unique case (op)
        OP_LOAD, OP_PAD: begin
          if (frm_room) begin
            if (bin_pos_r == BIN_W'(BIN_COUNT - 1)) begin
              bin_pos_r <= '0;
              frames_r  <= FR_W'(frames_r + 1'b1);
            end else begin
              bin_pos_r <= BIN_W'(bin_pos_r + 1'b1);
            end
          end
        end
        OP_START: begin
          k_r    <= k_clamp;
          ci_r   <= '0;
          bi_r   <= '0;
          pass_r <= '0;
        end
        OP_SEED_WR, OP_CLR, OP_UWR: begin
          bi_r <= b_last ? '0 : BIN_W'(bi_r + 1'b1);
          if (b_last) ci_r <= c_last ? '0 : CL_W'(ci_r + 1'b1);
          if (op == OP_CLR) begin
            for (int j = 0; j < MAX_CLUSTERS; j++) cnt_r[j] <= '0;
            changed_r <= 1'b0;
            fi_r      <= '0;
          end
        end
        OP_FRAME: begin
          ci_r    <= '0;
          bi_r    <= '0;
          found_r <= 1'b0;
          acc_r   <= '0;
        end
        OP_DACC: begin
          acc_r <= DIST_W'(acc_r + DIST_W'(adiff));
          bi_r  <= b_last ? '0 : BIN_W'(bi_r + 1'b1);
        end
        OP_DCMP: begin
          if (better) begin
            bd_r   <= acc_r;
            best_r <= ci_r;
          end
          found_r <= 1'b1;
          acc_r   <= '0;
          ci_r    <= c_last ? '0 : CL_W'(ci_r + 1'b1);
        end
        OP_AWR: begin
          // Every frame counts as moved on the first pass.
          if (pass_r == '0 || a_q != best_r) changed_r <= 1'b1;
          cnt_r[best_r] <= FR_W'(cnt_r[best_r] + 1'b1);
          bi_r          <= '0;
        end
        OP_SWR: begin
          bi_r <= b_last ? '0 : BIN_W'(bi_r + 1'b1);
          if (b_last) fi_r <= i_last ? '0 : FI_W'(fi_r + 1'b1);
        end
        OP_UCHK, OP_NEXTC: begin
          if (op == OP_NEXTC || cnt_r[ci_r] == '0) begin
            ci_r <= c_last ? '0 : CL_W'(ci_r + 1'b1);
          end
        end
        OP_PEND: pass_r <= PASS_W'(pass_r + 1'b1);
        OP_SCHK: begin
          if (cnt_r[ci_r] == '0) begin
            ci_r <= c_last ? '0 : CL_W'(ci_r + 1'b1);
          end else begin
            found_r <= 1'b0;
            fi_r    <= '0;
          end
        end
        OP_SARD: begin
          bi_r  <= '0;
          acc_r <= '0;
        end
        OP_SMAT: begin
          if (a_q != ci_r) fi_r <= i_last ? '0 : FI_W'(fi_r + 1'b1);
        end
        OP_SCMP: begin
          if (better) begin
            bd_r    <= acc_r;
            bestf_r <= fi_r;
          end
          found_r <= 1'b1;
          acc_r   <= '0;
          fi_r    <= i_last ? '0 : FI_W'(fi_r + 1'b1);
        end
        OP_SLD: begin
          out_cl_r   <= CLUSTER_IDX_W'(ci_r);
          out_fr_r   <= FRAME_IDX_W'(bestf_r);
          out_last_r <= last_c;
        end
        OP_CLEAR: begin
          frames_r  <= '0;
          bin_pos_r <= '0;
          pass_r    <= '0;
          for (int j = 0; j < MAX_CLUSTERS; j++) cnt_r[j] <= '0;
        end
        OP_NONE, OP_SEED_RD, OP_DRD, OP_SRD, OP_URD, OP_DIVGO: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    st.b_last   = b_last;
    st.c_last   = c_last;
    st.i_last   = i_last;
    st.pad_busy = bin_pos_r != '0 && frm_room;
    st.n_zero   = frames_r == '0;
    st.cnt_zero = cnt_r[ci_r] == '0;
    st.stop     = !changed_r || pass_r >= PASS_LIMIT;
    st.div_done = div_done;
    st.asg_hit  = a_q == ci_r;
  end

  assign out_cluster_index = out_cl_r;
  assign out_frame_index   = out_fr_r;
  assign out_last_result   = out_last_r;
endmodule
`default_nettype wire

// ===== sv/kmeans_histogram_keyframe_select.sv =====
// ----------------------------------------------------------------------------
// Key-frame selector by k-means clustering of frame histograms
// Loads histograms, clusters them with an L1 distance and reports one
// key frame per non-empty cluster.
// ----------------------------------------------------------------------------
// Bins are taken one per cycle while in_ready is high, BIN_COUNT bins to a
// frame; the transaction with in_end_of_set closes the set. in_ready then
// stays low while the block pads a partial last frame, seeds the centroids
// (a read and a write for each bin) and runs k-means passes. The mean
// divider, DV = 24 + log2(MAX_FRAMES) bits wide, retires one quotient bit a
// cycle. Up to 501 passes run. The selection then walks every frame for
// each non-empty cluster, and each result waits in an output register until
// it is taken. Every store has one read and one write port with registered
// read data, so distances are summed a bin at a time, with a read step and
// an accumulate step for each bin.
`default_nettype none
`include "kmeans_histogram_keyframe_select_defines.svh"
module kmeans_histogram_keyframe_select #(
  parameter int BIN_COUNT    = kmhks_pkg::BIN_COUNT_DEF,
  parameter int MAX_FRAMES   = kmhks_pkg::MAX_FRAMES_DEF,
  parameter int MAX_CLUSTERS = kmhks_pkg::MAX_CLUSTERS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [kmhks_pkg::CFG_W-1:0]         cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [kmhks_pkg::BIN_VALUE_W-1:0]   in_bin_value,
  input  wire logic                                in_end_of_set,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [kmhks_pkg::CLUSTER_IDX_W-1:0] out_cluster_index,
  output logic      [kmhks_pkg::FRAME_IDX_W-1:0]   out_frame_index,
  output logic                                     out_last_result
);
  import kmhks_pkg::*;

  op_t   op;
  stat_t st;

  kmhks_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_end_of_set, .out_ready, .st,
    .in_ready, .out_valid, .op
  );

  kmhks_dp #(
    .BIN_COUNT(BIN_COUNT), .MAX_FRAMES(MAX_FRAMES), .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_dp (
    .clk, .rst_n, .op, .st, .cfg_wr_en, .cfg_wr_data, .in_bin_value,
    .out_cluster_index, .out_frame_index, .out_last_result
  );

  `KMHKS_ASSERT(a_no_overlap, !(in_ready && out_valid))
  `KMHKS_ASSERT_NEXT(a_end_closes, in_valid && in_ready && in_end_of_set, !in_ready)
  `KMHKS_ASSERT_NEXT(a_last_ends, out_valid && out_ready && out_last_result, !out_valid)
endmodule
`default_nettype wire
